### rtl/vdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types, constants and helpers for the vertical delta codec.
// ----------------------------------------------------------------------------
package vdc_pkg;

	localparam int DATA_W  = 64;
	localparam int MAX_ROW = 1024;
	localparam int COL_W   = $clog2(MAX_ROW);
	localparam int LEN_W   = 11;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH_CODE = 2'd0,
		REG_COMBINE    = 2'd1,
		REG_DIRECTION  = 2'd2,
		REG_ROW_LENGTH = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WIDTH_8  = 2'd0,
		WIDTH_16 = 2'd1,
		WIDTH_32 = 2'd2,
		WIDTH_64 = 2'd3
	} width_code_t;

	function automatic logic [DATA_W-1:0] width_mask(input width_code_t code);
		logic [DATA_W-1:0] m;
		unique case (code)
			WIDTH_8:  m = 64'h0000_0000_0000_00FF;
			WIDTH_16: m = 64'h0000_0000_0000_FFFF;
			WIDTH_32: m = 64'h0000_0000_FFFF_FFFF;
			WIDTH_64: m = 64'hFFFF_FFFF_FFFF_FFFF;
			default:  m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

### rtl/vdc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdc_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module vdc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/vertical_delta_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_delta_codec
// Vertical delta coder: each element is combined with the element in the
// same column of the previous row, kept in a line memory.
// ----------------------------------------------------------------------------
// usage
//   request channel: sample, chunk_start with sample_valid / sample_stall.
//   result channel: coded with coded_valid / coded_stall.
//   config channel: cfg_index, cfg_data with cfg_valid / cfg_ready; ready is
//   always high; registers are to be written by the user only while the block is idle; the block does not enforce it.
// timing
//   one request per cycle sustained while coded_stall is low; an accepted
//   request is held in stage 1 and its result enters the output register
//   when it advances. the line memory read is issued at acceptance, combined
//   in the next cycle, and written back when the request moves to the output
//   register; a same-column write in that edge is forwarded.
// reset
//   column goes to 0 and the first row is assumed; the line memory is not
//   cleared. width 8 bits, subtract/add, encode, row length 1.
// stall
//   a stalled result holds in the output register; the stage before it still
//   takes one more request, then sample_stall rises until the result drains.
// ----------------------------------------------------------------------------
module vertical_delta_codec (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vdc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vdc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [vdc_pkg::DATA_W-1:0]          sample,
	input  logic                                chunk_start,
	output logic                                coded_valid,
	input  logic                                coded_stall,
	output logic [vdc_pkg::DATA_W-1:0]          coded
);

	vdc_pkg::width_code_t            width_code_q;
	logic                            combine_q;
	logic                            direction_q;
	logic [vdc_pkg::LEN_W-1:0]       row_length_q;

	logic [vdc_pkg::COL_W-1:0]       column_q;
	logic                            first_row_q;

	logic                            valid_s1;
	logic [vdc_pkg::DATA_W-1:0]      sample_s1;
	logic [vdc_pkg::COL_W-1:0]       col_s1;
	logic                            first_s1;
	logic                            fwd_s1;
	logic [vdc_pkg::DATA_W-1:0]      fwd_data_s1;

	logic                            out_valid_q;
	logic [vdc_pkg::DATA_W-1:0]      coded_q;

	logic [vdc_pkg::DATA_W-1:0]      mask;
	logic [vdc_pkg::LEN_W-1:0]       len_eff;
	logic                            accept;
	logic                            advance;
	logic [vdc_pkg::COL_W-1:0]       col_base;
	logic                            first_base;
	logic [vdc_pkg::COL_W-1:0]       col_cur;
	logic                            first_cur;
	logic [vdc_pkg::LEN_W-1:0]       col_next;

	logic [vdc_pkg::DATA_W-1:0]      ram_rdata;
	logic [vdc_pkg::DATA_W-1:0]      prev;
	logic [vdc_pkg::DATA_W-1:0]      result;
	logic [vdc_pkg::DATA_W-1:0]      store_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_code_q <= vdc_pkg::WIDTH_8;
			combine_q    <= 1'b0;
			direction_q  <= 1'b0;
			row_length_q <= vdc_pkg::LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (vdc_pkg::cfg_reg_t'(cfg_index))
				vdc_pkg::REG_WIDTH_CODE: width_code_q <= vdc_pkg::width_code_t'(cfg_data[1:0]);
				vdc_pkg::REG_COMBINE:    combine_q    <= cfg_data[0];
				vdc_pkg::REG_DIRECTION:  direction_q  <= cfg_data[0];
				vdc_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign mask = vdc_pkg::width_mask(width_code_q);

	always_comb begin
		priority if (row_length_q == '0) begin
			len_eff = vdc_pkg::LEN_W'(1);
		end else if (row_length_q > vdc_pkg::LEN_W'(vdc_pkg::MAX_ROW)) begin
			len_eff = vdc_pkg::LEN_W'(vdc_pkg::MAX_ROW);
		end else begin
			len_eff = row_length_q;
		end
	end

	// handshake
	assign advance      = valid_s1 && (!out_valid_q || !coded_stall);
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	// column tracking
	always_comb begin
		col_base   = chunk_start ? '0 : column_q;
		first_base = chunk_start ? 1'b1 : first_row_q;
		if ({1'b0, col_base} >= len_eff) begin
			col_cur   = '0;
			first_cur = 1'b0;
		end else begin
			col_cur   = col_base;
			first_cur = first_base;
		end
		col_next = {1'b0, col_cur} + vdc_pkg::LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (col_next >= len_eff) begin
				column_q    <= '0;
				first_row_q <= 1'b0;
			end else begin
				column_q    <= col_next[vdc_pkg::COL_W-1:0];
				first_row_q <= first_cur;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= sample & mask;
			col_s1      <= col_cur;
			first_s1    <= first_cur;
			fwd_s1      <= advance && (col_s1 == col_cur);
			fwd_data_s1 <= store_data;
		end
	end

	vdc_ram #(
		.WIDTH (vdc_pkg::DATA_W),
		.DEPTH (vdc_pkg::MAX_ROW)
	) u_row_store (
		.clk   (clk),
		.we    (advance),
		.waddr (col_s1),
		.wdata (store_data),
		.re    (accept),
		.raddr (col_cur),
		.rdata (ram_rdata)
	);

	// combine
	always_comb begin
		prev = (fwd_s1 ? fwd_data_s1 : ram_rdata) & mask;
		priority if (first_s1) begin
			result = sample_s1;
		end else if (combine_q) begin
			result = sample_s1 ^ prev;
		end else if (direction_q) begin
			result = (sample_s1 + prev) & mask;
		end else begin
			result = (sample_s1 - prev) & mask;
		end
		store_data = (direction_q && !first_s1) ? result : sample_s1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!coded_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			coded_q <= result;
		end
	end

	assign coded_valid = out_valid_q;
	assign coded       = coded_q;

endmodule
